[hw/rtl/led_strip_bit_encoder_assert.svh]
// Assertion macros for the LED strip bit encoder.
// Expects clk and rst_n in scope at the point of use.
`ifndef LED_STRIP_BIT_ENCODER_ASSERT_SVH
`define LED_STRIP_BIT_ENCODER_ASSERT_SVH

// Check prop at every clock edge outside reset.
`define LEDBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define LEDBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ledbe_pkg.sv]
// Shared constants and types for the LED strip bit encoder.
// No dependencies.
`default_nettype none

package ledbe_pkg;

  localparam int DUTY_BITS      = 16;
  localparam int DUTY_W         = 16;
  localparam int REP_W          = 10;
  localparam int ZDUTY_W        = 15;
  localparam int COLOUR_W       = 8;
  localparam int BITS_PER_PIXEL = 3 * COLOUR_W;
  localparam int SLOT_IDX_W     = $clog2(BITS_PER_PIXEL + 1);
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 15;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_BIT_DUTY    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_SLOT_COUNT = CFG_INDEX_W'(1);

  localparam logic [ZDUTY_W-1:0] ZERO_BIT_DUTY_RST    = ZDUTY_W'(30);
  localparam logic [REP_W-1:0]   RESET_SLOT_COUNT_RST = REP_W'(48);

  localparam logic [SLOT_IDX_W-1:0] LAST_DATA_IDX  = SLOT_IDX_W'(BITS_PER_PIXEL - 1);
  localparam logic [SLOT_IDX_W-1:0] RESET_SLOT_IDX = SLOT_IDX_W'(BITS_PER_PIXEL);

  localparam logic [REP_W-1:0] REP_ONE = REP_W'(1);

  typedef struct packed {
    logic [BITS_PER_PIXEL-1:0] bits;
    logic                      last_pixel;
    logic [DUTY_W-1:0]         duty_zero;
    logic [DUTY_W-1:0]         duty_one;
    logic [REP_W-1:0]          reset_rep;
  } pixel_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_stat_t;

endpackage

`default_nettype wire

[hw/rtl/led_strip_bit_encoder.sv]
// Top level of the LED strip bit encoder: front end, request queue, slot sequencer.
// Depends on ledbe_pkg, ledbe_front, ledbe_queue and ledbe_back.
//
//   Channel  Handshake             Carries
//   cfg      cfg_valid/cfg_ready   register index and write data
//   in       in_valid/in_ready     one pixel: green, red, blue, last_pixel
//   out      out_valid/out_ready   one slot: duty, slot_repeat, last_slot
//
// A pixel gives 24 results, 25 when it closes a frame, one per cycle from the
// output register unless out stalls; the slot index counter sets that figure.
// A two-entry queue takes new pixels while the sequencer works.
// Reset: registers return to duty 30 and 48 reset slots; queue and sequencer empty.
// Stalls on out hold the sequencer; in_ready falls only when the queue is full.
`default_nettype none

module led_strip_bit_encoder
  import ledbe_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic [COLOUR_W-1:0]    in_green,
  input  wire logic [COLOUR_W-1:0]    in_red,
  input  wire logic [COLOUR_W-1:0]    in_blue,
  input  wire logic                   in_last_pixel,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [DUTY_W-1:0]      out_duty,
  output      logic [REP_W-1:0]       out_slot_repeat,
  output      logic                   out_last_slot
);

  pixel_entry_t front_entry;
  pixel_entry_t q_data;
  queue_stat_t  q_stat;
  logic         q_pop;

  assign in_ready = !q_stat.full;

  ledbe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_green      (in_green),
    .in_red        (in_red),
    .in_blue       (in_blue),
    .in_last_pixel (in_last_pixel),
    .entry         (front_entry)
  );

  ledbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_entry),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  ledbe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_duty        (out_duty),
    .out_slot_repeat (out_slot_repeat),
    .out_last_slot   (out_last_slot)
  );

endmodule

`default_nettype wire

[hw/rtl/ledbe_front.sv]
// Front end: configuration registers, duty saturation and request packing.
// Depends on ledbe_pkg.
`default_nettype none

module ledbe_front
  import ledbe_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [COLOUR_W-1:0]    in_green,
  input  wire logic [COLOUR_W-1:0]    in_red,
  input  wire logic [COLOUR_W-1:0]    in_blue,
  input  wire logic                   in_last_pixel,
  output      pixel_entry_t           entry
);

  localparam int CALC_W = 33;
  localparam logic [CALC_W-1:0] DUTY_SAT = (CALC_W'(1) << DUTY_BITS) - CALC_W'(1);

  logic [ZDUTY_W-1:0] zero_bit_duty_r;
  logic [REP_W-1:0]   reset_slot_count_r;
  logic [CALC_W-1:0]  d0_full;
  logic [CALC_W-1:0]  d1_full;
  logic [CALC_W-1:0]  d0_sat;
  logic [CALC_W-1:0]  d1_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_bit_duty_r    <= ZERO_BIT_DUTY_RST;
      reset_slot_count_r <= RESET_SLOT_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ZERO_BIT_DUTY:    zero_bit_duty_r    <= cfg_data[ZDUTY_W-1:0];
        REG_RESET_SLOT_COUNT: reset_slot_count_r <= cfg_data[REP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    d0_full = CALC_W'(zero_bit_duty_r);
    d1_full = CALC_W'(zero_bit_duty_r) << 1;
    d0_sat  = (d0_full > DUTY_SAT) ? DUTY_SAT : d0_full;
    d1_sat  = (d1_full > DUTY_SAT) ? DUTY_SAT : d1_full;

    entry.bits       = {in_green, in_red, in_blue};
    entry.last_pixel = in_last_pixel;
    entry.duty_zero  = d0_sat[DUTY_W-1:0];
    entry.duty_one   = d1_sat[DUTY_W-1:0];
    entry.reset_rep  = (reset_slot_count_r == '0) ? REP_ONE : reset_slot_count_r;
  end

endmodule

`default_nettype wire

[hw/rtl/ledbe_queue.sv]
// Short request queue between front end and slot sequencer.
// Depends on ledbe_pkg.
`default_nettype none

module ledbe_queue
  import ledbe_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire pixel_entry_t push_data,
  input  wire logic         pop,
  output      pixel_entry_t pop_data,
  output      queue_stat_t  stat
);

  pixel_entry_t       ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic [QPTR_W-1:0]  wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ledbe_back.sv]
// Slot sequencer: shifts a queued request out as duty slots and a reset run.
// Depends on ledbe_pkg and led_strip_bit_encoder_assert.svh.
`default_nettype none

module ledbe_back
  import ledbe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire queue_stat_t       q_stat,
  input  wire pixel_entry_t      q_data,
  output      logic              q_pop,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [DUTY_W-1:0] out_duty,
  output      logic [REP_W-1:0]  out_slot_repeat,
  output      logic              out_last_slot
);

  `include "led_strip_bit_encoder_assert.svh"

  logic                  busy_r;
  logic                  busy_nxt;
  logic [SLOT_IDX_W-1:0] idx_r;
  logic [SLOT_IDX_W-1:0] idx_nxt;
  pixel_entry_t          ent_r;
  pixel_entry_t          ent_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [DUTY_W-1:0]     out_duty_r;
  logic [DUTY_W-1:0]     out_duty_nxt;
  logic [REP_W-1:0]      out_slot_repeat_r;
  logic [REP_W-1:0]      out_slot_repeat_nxt;
  logic                  out_last_slot_r;
  logic                  out_last_slot_nxt;
  logic                  adv;
  logic                  emit;
  logic                  is_reset;
  logic                  done;
  logic                  load;

  assign out_valid       = out_valid_r;
  assign out_duty        = out_duty_r;
  assign out_slot_repeat = out_slot_repeat_r;
  assign out_last_slot   = out_last_slot_r;

  assign adv      = !out_valid_r || out_ready;
  assign emit     = busy_r && adv;
  assign is_reset = (idx_r == RESET_SLOT_IDX);
  assign done     = is_reset || ((idx_r == LAST_DATA_IDX) && !ent_r.last_pixel);
  assign load     = q_stat.valid && (!busy_r || (emit && done));
  assign q_pop    = load;

  always_comb begin
    busy_nxt            = busy_r;
    idx_nxt             = idx_r;
    ent_nxt             = ent_r;
    out_valid_nxt       = out_valid_r;
    out_duty_nxt        = out_duty_r;
    out_slot_repeat_nxt = out_slot_repeat_r;
    out_last_slot_nxt   = out_last_slot_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      if (is_reset) begin
        out_duty_nxt        = '0;
        out_slot_repeat_nxt = ent_r.reset_rep;
        out_last_slot_nxt   = 1'b1;
      end else begin
        out_duty_nxt        = ent_r.bits[BITS_PER_PIXEL-1] ? ent_r.duty_one : ent_r.duty_zero;
        out_slot_repeat_nxt = REP_ONE;
        out_last_slot_nxt   = done;
      end
      ent_nxt.bits = ent_r.bits << 1;
      idx_nxt      = idx_r + SLOT_IDX_W'(1);
      if (done) begin
        busy_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      ent_nxt  = q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r             <= ent_nxt;
    out_duty_r        <= out_duty_nxt;
    out_slot_repeat_r <= out_slot_repeat_nxt;
    out_last_slot_r   <= out_last_slot_nxt;
  end

  `LEDBE_ASSERT(a_idx_range, busy_r |-> (idx_r <= RESET_SLOT_IDX), "slot index out of range")
  `LEDBE_ASSERT(a_reset_only_last, (busy_r && is_reset) |-> ent_r.last_pixel, "reset run without last pixel")
  `LEDBE_ASSERT_NEXT(a_done_marks_last, emit && done, out_valid_r && out_last_slot_r, "final slot not marked")
  `LEDBE_ASSERT_NEXT(a_hold_on_stall, busy_r && !adv, $stable(idx_r), "slot index moved while stalled")

endmodule

`default_nettype wire
